@@ rtl/spr_pkg.sv @@
package spr_pkg;

  // Fixed field widths
  localparam int GAIN_W     = 32;
  localparam int THRESH_W   = 24;
  localparam int LIM_W      = 23;
  localparam int INT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Products are saturated to +-2^61, which needs 63 bits when it can occur
  localparam int SAT_PROD_W = 63;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KB     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OLIM   = 3'd7;

  typedef struct packed {
    logic signed [GAIN_W-1:0]   kp;
    logic signed [GAIN_W-1:0]   kb;
    logic signed [GAIN_W-1:0]   ki;
    logic signed [GAIN_W-1:0]   kd;
    logic        [THRESH_W-1:0] thresh;
    logic                       sect_en;
    logic        [LIM_W-1:0]    ilim;
    logic        [LIM_W-1:0]    olim;
  } cfg_t;

  // Width of a saturated product of an aw-bit operand and a gain
  function automatic int sat_prod_w(int aw);
    return (aw + GAIN_W > SAT_PROD_W - 1) ? SAT_PROD_W : aw + GAIN_W;
  endfunction

endpackage

@@ rtl/spr_cfg_regs.sv @@
module spr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [spr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output spr_pkg::cfg_t                      cfg
);

  spr_pkg::cfg_t cfg_r;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        spr_pkg::REG_KP:     cfg_r.kp      <= $signed(cfg_wdata);
        spr_pkg::REG_KB:     cfg_r.kb      <= $signed(cfg_wdata);
        spr_pkg::REG_KI:     cfg_r.ki      <= $signed(cfg_wdata);
        spr_pkg::REG_KD:     cfg_r.kd      <= $signed(cfg_wdata);
        spr_pkg::REG_THRESH: cfg_r.thresh  <= cfg_wdata[spr_pkg::THRESH_W-1:0];
        spr_pkg::REG_SECT:   cfg_r.sect_en <= cfg_wdata[0];
        spr_pkg::REG_ILIM:   cfg_r.ilim    <= cfg_wdata[spr_pkg::LIM_W-1:0];
        spr_pkg::REG_OLIM:   cfg_r.olim    <= cfg_wdata[spr_pkg::LIM_W-1:0];
        default:             cfg_r         <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/spr_mul_sat.sv @@
module spr_mul_sat #(
  parameter int A_W = 25
) (
  input  logic signed [A_W-1:0]                           a,
  input  logic signed [spr_pkg::GAIN_W-1:0]               b,
  output logic signed [spr_pkg::sat_prod_w(A_W)-1:0]      y
);

  localparam int PW = A_W + spr_pkg::GAIN_W;
  localparam int OW = spr_pkg::sat_prod_w(A_W);
  localparam int XW = (PW > spr_pkg::SAT_PROD_W) ? PW : spr_pkg::SAT_PROD_W;
  localparam logic signed [XW-1:0] LIM = $signed({{(XW-62){1'b0}}, 1'b1, 61'b0});

  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] prod_x;
  logic signed [XW-1:0] sat;

  assign prod   = a * b;
  assign prod_x = XW'(prod);

  // Clamp magnitude to 2^61; never fires at narrow widths
  always_comb begin
    if (prod_x > LIM) begin
      sat = LIM;
    end else if (prod_x < -LIM) begin
      sat = -LIM;
    end else begin
      sat = prod_x;
    end
  end

  assign y = OW'(sat);

endmodule

@@ rtl/spr_integrator.sv @@
module spr_integrator #(
  parameter int IP_W = 57,
  parameter int FRAC = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic signed [IP_W-1:0]            ip,
  input  logic [spr_pkg::LIM_W-1:0]         ilim,
  output logic signed [spr_pkg::INT_W-1:0]  integ
);

  localparam int AUX_W = ((IP_W > spr_pkg::INT_W) ? IP_W : spr_pkg::INT_W) + 1;

  logic signed [spr_pkg::INT_W-1:0] integ_r;
  logic signed [spr_pkg::INT_W-1:0] integ_nxt;
  logic signed [AUX_W-1:0]          aux;
  logic signed [AUX_W-1:0]          lim_s;

  assign aux   = AUX_W'(integ_r) + AUX_W'(ip);
  assign lim_s = $signed(AUX_W'(ilim)) <<< FRAC;

  // Accumulate and clamp to the symmetric limit
  always_comb begin
    if (aux > lim_s) begin
      integ_nxt = spr_pkg::INT_W'(lim_s);
    end else if (aux < -lim_s) begin
      integ_nxt = spr_pkg::INT_W'(-lim_s);
    end else begin
      integ_nxt = spr_pkg::INT_W'(aux);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (load) begin
      integ_r <= integ_nxt;
    end
  end

  assign integ = integ_r;

endmodule

@@ rtl/sectioned_pid_regulator.sv @@
// Channel  Direction  Payload
// in_      slave      tdata: reference, feedback (DATA_WIDTH each)
// out_     master     tdata: drive (DATA_WIDTH)
// cfg_     write      index 0..7, data up to 32 bits
//
// One item per cycle while the output is not stalled; six register stages (input, error,
// multiply, integrate, sum, saturate) lie between an accepted input item and its drive.
// The integrator and previous error update once per item, in order, as it moves down.
// Synchronous active-low reset clears control, configuration, integral and error state.
// A stalled output holds each stage that is full; empty stages still fill.
module sectioned_pid_regulator #(
  parameter int DATA_WIDTH     = 24,
  parameter int GAIN_FRAC_BITS = 16,
  localparam int IN_TD_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TD_W = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_TD_W-1:0]                 in_tdata,   // reference, feedback
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [OUT_TD_W-1:0]                out_tdata,  // drive
  input  logic                               cfg_wr_en,
  input  logic [spr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int DW     = DATA_WIDTH;
  localparam int E_W    = DW + 1;
  localparam int D_W    = DW + 2;
  localparam int PP_W   = spr_pkg::sat_prod_w(E_W);
  localparam int DP_W   = spr_pkg::sat_prod_w(D_W);
  localparam int CMP_W  = (E_W > spr_pkg::THRESH_W) ? E_W : spr_pkg::THRESH_W;
  localparam int MX1_W  = (PP_W > DP_W) ? PP_W : DP_W;
  localparam int MX_W   = (MX1_W > spr_pkg::INT_W) ? MX1_W : spr_pkg::INT_W;
  localparam int SUM_W  = MX_W + 2;
  localparam int DRV_W  = ((DW > spr_pkg::LIM_W) ? DW : spr_pkg::LIM_W) + 1;
  localparam logic signed [DRV_W-1:0] DMAX = $signed(DRV_W'({1'b0, {(DW-1){1'b1}}}));

  spr_pkg::cfg_t cfg;

  spr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stage valids and flow control
  logic v0_r, v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic free0, free1, free2, free3, free4, free5;

  assign free5 = !out_valid_r || out_tready;
  assign free4 = !v4_r || free5;
  assign free3 = !v3_r || free4;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign free0 = !v0_r || free1;
  assign in_tready = free0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free0) v0_r <= in_tvalid;
      if (free1) v1_r <= v0_r;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (free4) v4_r <= v3_r;
      if (free5) out_valid_r <= v4_r;
    end
  end

  // Input register
  logic signed [DW-1:0] ref0_r, fb0_r;

  always_ff @(posedge clk) begin
    if (free0 && in_tvalid) begin
      ref0_r <= $signed(in_tdata[DW-1:0]);
      fb0_r  <= $signed(in_tdata[2*DW-1:DW]);
    end
  end

  // Error, error change and proportional gain select
  logic signed [E_W-1:0]             err;
  logic        [E_W-1:0]             err_abs;
  logic signed [E_W-1:0]             prev_err_r;
  logic signed [E_W-1:0]             err1_r;
  logic signed [D_W-1:0]             diff1_r;
  logic signed [spr_pkg::GAIN_W-1:0] kp1_r;
  logic                              boost;

  assign err     = E_W'(ref0_r) - E_W'(fb0_r);
  assign err_abs = err[E_W-1] ? E_W'(-err) : E_W'(err);
  assign boost   = cfg.sect_en && (CMP_W'(err_abs) >= CMP_W'(cfg.thresh));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (free1 && v0_r) begin
      prev_err_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (free1 && v0_r) begin
      err1_r  <= err;
      diff1_r <= D_W'(err) - D_W'(prev_err_r);
      kp1_r   <= boost ? cfg.kb : cfg.kp;
    end
  end

  // Products
  logic signed [PP_W-1:0] p_prod, ip_prod;
  logic signed [DP_W-1:0] d_prod;
  logic signed [PP_W-1:0] p2_r, ip2_r;
  logic signed [DP_W-1:0] d2_r;

  spr_mul_sat #(.A_W(E_W)) u_mul_p (.a(err1_r),  .b(kp1_r),  .y(p_prod));
  spr_mul_sat #(.A_W(E_W)) u_mul_i (.a(err1_r),  .b(cfg.ki), .y(ip_prod));
  spr_mul_sat #(.A_W(D_W)) u_mul_d (.a(diff1_r), .b(cfg.kd), .y(d_prod));

  always_ff @(posedge clk) begin
    if (free2 && v1_r) begin
      p2_r  <= p_prod;
      ip2_r <= ip_prod;
      d2_r  <= d_prod;
    end
  end

  // Integrator; its register holds the integral of the item in stage 3
  logic signed [spr_pkg::INT_W-1:0] integ;
  logic signed [PP_W-1:0]           p3_r;
  logic signed [DP_W-1:0]           d3_r;

  spr_integrator #(.IP_W(PP_W), .FRAC(GAIN_FRAC_BITS)) u_int (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (free3 && v2_r),
    .ip    (ip2_r),
    .ilim  (cfg.ilim),
    .integ (integ)
  );

  always_ff @(posedge clk) begin
    if (free3 && v2_r) begin
      p3_r <= p2_r;
      d3_r <= d2_r;
    end
  end

  // Sum of the three terms
  logic signed [SUM_W-1:0] sum4_r;

  always_ff @(posedge clk) begin
    if (free4 && v3_r) begin
      sum4_r <= SUM_W'(p3_r) + SUM_W'(integ) + SUM_W'(d3_r);
    end
  end

  // Saturate, truncate toward zero, fit to the drive width
  logic signed [SUM_W-1:0] olim_s;
  logic signed [SUM_W-1:0] bias;
  logic signed [SUM_W-1:0] shifted;
  logic signed [DRV_W-1:0] olim_d;
  logic signed [DRV_W-1:0] drive_sat;
  logic signed [DRV_W-1:0] drive_fit;
  logic        [DW-1:0]    drive_r;

  assign olim_s  = $signed(SUM_W'(cfg.olim)) <<< GAIN_FRAC_BITS;
  assign olim_d  = $signed(DRV_W'(cfg.olim));
  assign bias    = sum4_r[SUM_W-1] ? $signed(SUM_W'({GAIN_FRAC_BITS{1'b1}})) : '0;
  assign shifted = (sum4_r + bias) >>> GAIN_FRAC_BITS;

  always_comb begin
    if (sum4_r >= olim_s) begin
      drive_sat = olim_d;
    end else if (sum4_r < -olim_s) begin
      drive_sat = -olim_d;
    end else begin
      drive_sat = DRV_W'(shifted);
    end
    if (drive_sat > DMAX) begin
      drive_fit = DMAX;
    end else if (drive_sat < -DMAX - DRV_W'(1)) begin
      drive_fit = -DMAX - DRV_W'(1);
    end else begin
      drive_fit = drive_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (free5 && v4_r) begin
      drive_r <= drive_fit[DW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TD_W'(drive_r);

endmodule

@@ tb/sectioned_pid_regulator_test.sv @@
`timescale 1ns / 1ps

module sectioned_pid_regulator_test;

  localparam int DW          = 24;
  localparam int FRAC        = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_CAP  = 200;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [2*DW-1:0]                   in_tdata;   // reference, feedback
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [DW-1:0]                     out_tdata;  // drive
  logic                              cfg_wr_en;
  logic [spr_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [spr_pkg::CFG_DATA_W-1:0]    cfg_wdata;

  // Regulator model: register copy and loop state
  spr_pkg::cfg_t ctl_regs;
  longint        integral_acc;
  longint        last_error;

  logic signed [DW-1:0] expected_drive[$];
  logic signed [DW-1:0] want;

  int in_idle_pct  = 15;
  int out_idle_pct = 73;
  int mismatch_count;
  int results_checked;
  int steps_sent;
  int writes_done;
  int cycle_count;

  sectioned_pid_regulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d drive results outstanding", $time,
               expected_drive.size());
      $display("[sectioned_pid_regulator] ERROR");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Compare each accepted drive with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_drive.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: drive %0d arrived with none expected", $time,
                   $signed(out_tdata[DW-1:0]));
      end else begin
        want = expected_drive.pop_front();
        results_checked++;
        if (out_tdata[DW-1:0] !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want,
                     $signed(out_tdata[DW-1:0]));
        end
      end
    end
  end

  // One control step: sectioned P, clamped I, D on error change, saturate, truncate
  function automatic logic signed [DW-1:0] predict_drive(logic signed [DW-1:0] r,
                                                        logic signed [DW-1:0] f);
    longint e, gain, pterm, isum, ilim_fx, dterm, total, olim_fx, drv, dmax;
    e = longint'(r) - longint'(f);
    gain = longint'($signed(ctl_regs.kp));
    if (ctl_regs.sect_en && ((e < 0) ? -e : e) >= longint'(ctl_regs.thresh))
      gain = longint'($signed(ctl_regs.kb));
    pterm = e * gain;
    ilim_fx = longint'(ctl_regs.ilim) <<< FRAC;
    isum = integral_acc + e * longint'($signed(ctl_regs.ki));
    if (isum > ilim_fx)
      isum = ilim_fx;
    else if (isum < -ilim_fx)
      isum = -ilim_fx;
    integral_acc = isum;
    dterm = (e - last_error) * longint'($signed(ctl_regs.kd));
    last_error = e;
    total = pterm + integral_acc + dterm;
    olim_fx = longint'(ctl_regs.olim) <<< FRAC;
    if (total >= olim_fx)
      drv = longint'(ctl_regs.olim);
    else if (total < -olim_fx)
      drv = -longint'(ctl_regs.olim);
    else if (total < 0)
      drv = -((-total) >> FRAC);
    else
      drv = total >> FRAC;
    dmax = (longint'(1) <<< (DW - 1)) - 1;
    if (drv > dmax)
      drv = dmax;
    else if (drv < -dmax - 1)
      drv = -dmax - 1;
    return drv[DW-1:0];
  endfunction

  // Write one register and mirror it in the model
  task automatic program_reg(input logic [spr_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      spr_pkg::REG_KP:     ctl_regs.kp = data;
      spr_pkg::REG_KB:     ctl_regs.kb = data;
      spr_pkg::REG_KI:     ctl_regs.ki = data;
      spr_pkg::REG_KD:     ctl_regs.kd = data;
      spr_pkg::REG_THRESH: ctl_regs.thresh = data[spr_pkg::THRESH_W-1:0];
      spr_pkg::REG_SECT:   ctl_regs.sect_en = data[0];
      spr_pkg::REG_ILIM:   ctl_regs.ilim = data[spr_pkg::LIM_W-1:0];
      spr_pkg::REG_OLIM:   ctl_regs.olim = data[spr_pkg::LIM_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // Offer one step after a random gap and record its prediction on acceptance
  task automatic send_step(input int r, input int f);
    logic signed [DW-1:0] rv, fv;
    rv = r[DW-1:0];
    fv = f[DW-1:0];
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {fv, rv};
    do @(posedge clk); while (!in_tready);
    expected_drive.push_back(predict_drive(rv, fv));
    steps_sent++;
  endtask

  // Drop valid and hold until every predicted drive has come back
  task automatic drain_results;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(3))
      0: return 8388607;
      1: return -8388608;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Mostly gains within +-4.0, sometimes full range or zero
  function automatic logic [31:0] rand_gain();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h0;
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // Program all eight registers: two extreme corners, otherwise random
  task automatic load_setting(input int kind);
    logic [31:0] kp_w, kb_w, ki_w, kd_w, th_w, se_w, il_w, ol_w;
    if (kind == 0) begin
      kp_w = 32'h7FFF_FFFF; kb_w = 32'h8000_0000; ki_w = 32'h7FFF_FFFF; kd_w = 32'h8000_0000;
      th_w = 32'hFFFF_FFFF; se_w = 32'h1; il_w = 32'h007F_FFFF; ol_w = 32'h007F_FFFF;
    end else if (kind == 1) begin
      kp_w = 32'h8000_0000; kb_w = 32'h7FFF_FFFF; ki_w = 32'h8000_0000; kd_w = 32'h7FFF_FFFF;
      th_w = 32'h0; se_w = 32'hFFFF_FFFF; il_w = 32'h0; ol_w = 32'hFFFF_FFFF;
    end else begin
      kp_w = rand_gain();
      kb_w = rand_gain();
      ki_w = rand_gain();
      kd_w = rand_gain();
      th_w = ($urandom & 32'hFF00_0000) | $urandom_range((1 << $urandom_range(16)) - 1);
      se_w = $urandom;
      il_w = ($urandom & 32'hFF80_0000) | $urandom_range((1 << $urandom_range(23)) - 1);
      ol_w = ($urandom & 32'hFF80_0000) | $urandom_range((1 << $urandom_range(23)) - 1);
    end
    program_reg(spr_pkg::REG_KP, kp_w);
    program_reg(spr_pkg::REG_KB, kb_w);
    program_reg(spr_pkg::REG_KI, ki_w);
    program_reg(spr_pkg::REG_KD, kd_w);
    program_reg(spr_pkg::REG_THRESH, th_w);
    program_reg(spr_pkg::REG_SECT, se_w);
    program_reg(spr_pkg::REG_ILIM, il_w);
    program_reg(spr_pkg::REG_OLIM, ol_w);
  endtask

  // All registers zero after reset: drive stays at zero
  task automatic test_reset_defaults;
    send_step(100, -50);
    send_step(-8388608, 8388607);
  endtask

  // Boosted gain at and above the threshold, normal gain below or when disabled
  task automatic test_section_switch;
    drain_results;
    program_reg(spr_pkg::REG_KP, 32'h0001_0000);
    program_reg(spr_pkg::REG_KB, 32'h0004_0000);
    program_reg(spr_pkg::REG_KI, 32'h0);
    program_reg(spr_pkg::REG_KD, 32'h0);
    program_reg(spr_pkg::REG_THRESH, 32'd100);
    program_reg(spr_pkg::REG_SECT, 32'h1);
    program_reg(spr_pkg::REG_ILIM, 32'h0);
    program_reg(spr_pkg::REG_OLIM, 32'd5000);
    send_step(99, 0);
    send_step(100, 0);
    send_step(0, 100);
    send_step(0, 99);
    drain_results;
    program_reg(spr_pkg::REG_SECT, 32'h0);
    send_step(100, 0);
  endtask

  // Truncation toward zero and saturation exactly at the output limit
  task automatic test_rounding_and_saturation;
    drain_results;
    program_reg(spr_pkg::REG_KP, 32'h0000_8000);
    program_reg(spr_pkg::REG_OLIM, 32'd50);
    send_step(3, 0);
    send_step(0, 3);
    send_step(1, 0);
    send_step(100, 0);
    send_step(0, 100);
    send_step(0, 102);
  endtask

  // Integral runs into its clamp on both sides; derivative follows error change
  task automatic test_integral_clamp;
    drain_results;
    program_reg(spr_pkg::REG_KP, 32'h0);
    program_reg(spr_pkg::REG_KI, 32'h0001_0000);
    program_reg(spr_pkg::REG_KD, 32'h0000_8000);
    program_reg(spr_pkg::REG_ILIM, 32'd10);
    program_reg(spr_pkg::REG_OLIM, 32'h007F_FFFF);
    send_step(4, 0);
    send_step(4, 0);
    send_step(4, 0);
    send_step(0, 30);
    send_step(0, 0);
  endtask

  // Extreme gains and inputs, then a zero output limit
  task automatic test_extremes;
    drain_results;
    load_setting(0);
    send_step(8388607, -8388608);
    send_step(-8388608, 8388607);
    send_step(0, 0);
    send_step(-1, 0);
    drain_results;
    program_reg(spr_pkg::REG_OLIM, 32'h0);
    send_step(-8388608, 8388607);
  endtask

  // Several settings per idle pattern; mostly tracking steps near a setpoint
  task automatic test_random_regulation(input int sender_idle, input int receiver_idle);
    int setpoint, r, f, style;
    setpoint = 0;
    in_idle_pct  = sender_idle;
    out_idle_pct = receiver_idle;
    for (int phase = 0; phase < 4; phase++) begin
      drain_results;
      load_setting(phase);
      for (int k = 0; k < 135; k++) begin
        if ($urandom_range(49) == 0)
          setpoint = int'($urandom_range(16777215)) - 8388608;
        style = $urandom_range(9);
        if (style < 2) begin
          r = $urandom;
          f = $urandom;
        end else if (style < 8) begin
          r = setpoint;
          f = setpoint + int'($urandom_range(2048)) - 1024;
          if (f > 8388607)
            f = 8388607;
          else if (f < -8388608)
            f = -8388608;
        end else if (style == 8) begin
          r = pick_extreme();
          f = pick_extreme();
        end else begin
          r = int'($urandom_range(512)) - 256;
          f = int'($urandom_range(512)) - 256;
        end
        send_step(r, f);
      end
    end
    drain_results;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    ctl_regs     = '0;
    integral_acc = 0;
    last_error   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults;
    test_section_switch;
    test_rounding_and_saturation;
    test_integral_clamp;
    test_extremes;
    test_random_regulation(15, 73);
    test_random_regulation(73, 15);
    test_random_regulation(0, 0);

    // Let the pipeline settle and catch any stray result
    repeat (20) @(posedge clk);
    if (expected_drive.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d drive results never arrived", $time, expected_drive.size());
    end

    $display("Covered reset defaults, gain sectioning, truncation, both clamps and corner gains");
    $display("with %0d register writes; %0d steps sent, %0d drive results checked.",
             writes_done, steps_sent, results_checked);
    if (mismatch_count == 0) begin
      $display("[sectioned_pid_regulator] OK");
    end else begin
      $display("[sectioned_pid_regulator] ERROR");
    end
    $finish;
  end

endmodule
